// ===== rtl/abkf_pkg.sv =====
// Shared types, constants and helpers for the angle/bias Kalman filter.
// No dependencies; every other file imports this package.
package abkf_pkg;

    localparam int NUM_AXES_DEF = 2;

    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int MEAS_W     = 25;
    localparam int RATE_W     = 28;
    localparam int DT_W       = 24;
    localparam int DATA_W     = 32;
    localparam int OPA_W      = 34;   // widest multiplier operand A
    localparam int OPB_W      = 33;   // widest multiplier operand B
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int RND_W      = PROD_W - 16;
    localparam int ACC_W      = RND_W + 1;
    localparam int S_W        = 34;   // innovation variance P00 + R

    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_Q = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_Q  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_R  = 2'd2;

    localparam logic [CFG_W-1:0] ANGLE_Q_RST = 17'd66;
    localparam logic [CFG_W-1:0] BIAS_Q_RST  = 17'd197;
    localparam logic [CFG_W-1:0] MEAS_R_RST  = 17'd1966;

    // update steps, in issue order
    typedef enum logic [3:0] {
        OP_ANG_PRED,
        OP_P00_PRED,
        OP_P01_PRED,
        OP_P10_PRED,
        OP_P11_PRED,
        OP_K0,
        OP_K1,
        OP_ANG_CORR,
        OP_BIAS_CORR,
        OP_P00_CORR,
        OP_P01_CORR,
        OP_P10_CORR,
        OP_P11_CORR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic accept;
        logic load;
        logic mul;
        logic rnd;
        logic acc;
        logic div_start;
        logic finish;
    } abkf_cmd_t;

    typedef struct packed {
        logic axis_ok;
        logic div_done;
    } abkf_status_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] res;
        if (&x[ACC_W-1:DATA_W-1] || ~|x[ACC_W-1:DATA_W-1]) begin
            res = x[DATA_W-1:0];
        end else if (x[ACC_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Q16.16 x Q16.16 steps: shift 16 and saturate the product
    function automatic logic is_qq(input op_t op);
        logic res;
        case (op)
            OP_ANG_PRED, OP_P00_PRED, OP_P01_PRED,
            OP_P10_PRED, OP_P11_PRED: res = 1'b0;
            default:                  res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/abkf_div.sv =====
// Restoring divider forming the saturated Q16.16 reciprocal 2^32 / s.
// Depends on abkf_pkg.
module abkf_div
    import abkf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [S_W-1:0]    s_in,
    output logic                     done,
    output logic signed [DATA_W-1:0] inv
);

    localparam int STEPS = 33;   // quotient bits of 2^32 / |s|
    localparam int CNT_W = $clog2(STEPS);

    logic [S_W:0]       rem_reg, rem_next;
    logic [STEPS-1:0]   quo_reg, quo_next;
    logic [S_W-1:0]     den_reg, den_next;
    logic               neg_reg, neg_next, zero_reg, zero_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [S_W:0]       shifted;
    logic               fits;
    logic signed [ACC_W-1:0] q_ext;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // numerator has only its top bit set
        shifted   = {rem_reg[S_W-1:0], (cnt_reg == CNT_W'(STEPS - 1))};
        fits      = shifted >= {1'b0, den_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = '0;
            den_next  = s_in[S_W-1] ? S_W'(-s_in) : S_W'(s_in);
            neg_next  = s_in[S_W-1];
            zero_next = (s_in == '0);
            cnt_next  = CNT_W'(STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? shifted - {1'b0, den_reg} : shifted;
            quo_next = {quo_reg[STEPS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb begin
        q_ext = neg_reg ? -ACC_W'(signed'({1'b0, quo_reg})) : ACC_W'(signed'({1'b0, quo_reg}));
        inv   = zero_reg ? '0 : sat32(q_ext);
    end

    assign done = done_reg;

endmodule

// ===== rtl/abkf_ctrl.sv =====
// Sequencer for the filter update: accept, load, per-step multiply/round/accumulate,
// reciprocal wait and result hand-off. Depends on abkf_pkg.
module abkf_ctrl
    import abkf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  abkf_status_t status,
    output abkf_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOAD = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_RND  = 8'b0000_1000,
        ST_ACC  = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_DIVW = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.op       = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                op_next    = OP_ANG_PRED;
                state_next = status.axis_ok ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.rnd    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                case (op_reg)
                    OP_P01_PRED: begin
                        // same rounded P11*dt feeds P10
                        op_next    = OP_P10_PRED;
                        state_next = ST_ACC;
                    end
                    OP_P11_PRED: state_next = ST_DIV;
                    OP_P11_CORR: state_next = ST_DONE;
                    default: begin
                        op_next    = op_t'(op_reg + 4'd1);
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (status.div_done) begin
                    op_next    = OP_K0;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_ANG_PRED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/abkf_dp.sv =====
// Datapath: per-axis state, shared multiplier with round/saturate stage,
// accumulator, reciprocal unit, registers and result payload. Depends on abkf_pkg, abkf_div.
module abkf_dp
    import abkf_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  abkf_cmd_t                cmd,
    output abkf_status_t             status,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_axis,
    input  logic signed [MEAS_W-1:0] s_measured_angle,
    input  logic signed [RATE_W-1:0] s_gyro_rate,
    input  logic [DT_W-1:0]          s_time_step,
    output logic                     m_axis_out,
    output logic signed [DATA_W-1:0] m_angle_estimate,
    output logic signed [DATA_W-1:0] m_bias_estimate
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [CFG_W-1:0] q_ang_reg, q_bias_reg, r_meas_reg;

    logic signed [DATA_W-1:0] ang_mem  [NUM_AXES];
    logic signed [DATA_W-1:0] bias_mem [NUM_AXES];
    logic signed [DATA_W-1:0] p00_mem  [NUM_AXES];
    logic signed [DATA_W-1:0] p01_mem  [NUM_AXES];
    logic signed [DATA_W-1:0] p10_mem  [NUM_AXES];
    logic signed [DATA_W-1:0] p11_mem  [NUM_AXES];

    logic                     axis_reg;
    logic signed [MEAS_W-1:0] meas_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [AXW-1:0]           idx;
    logic                     axis_ok;

    logic signed [DATA_W-1:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DATA_W-1:0] y_reg, inv_reg, k0_reg, k1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RND_W-1:0]  rnd_reg;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] rnd_sum, rnd_shd;
    logic signed [RND_W-1:0]  rnd_next;
    logic signed [DATA_W-1:0] acc_base, acc_res;
    logic                     acc_sub;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [S_W-1:0]    s_val;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_inv;

    assign idx     = AXW'(axis_reg);
    assign axis_ok = int'(axis_reg) < NUM_AXES;
    assign status  = '{axis_ok: axis_ok, div_done: div_done};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_ang_reg  <= ANGLE_Q_RST;
            q_bias_reg <= BIAS_Q_RST;
            r_meas_reg <= MEAS_R_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ANGLE_Q: q_ang_reg  <= cfg_wdata;
                CFG_BIAS_Q:  q_bias_reg <= cfg_wdata;
                CFG_MEAS_R:  r_meas_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        op_a = OPA_W'(p00_reg);
        op_b = OPB_W'(inv_reg);
        case (cmd.op)
            OP_ANG_PRED: begin
                op_a = OPA_W'(rate_reg) - OPA_W'(bias_reg);
                op_b = OPB_W'(dt_reg);
            end
            OP_P00_PRED: begin
                op_a = OPA_W'(q_ang_reg) - OPA_W'(p10_reg) - OPA_W'(p01_reg);
                op_b = OPB_W'(dt_reg);
            end
            OP_P01_PRED, OP_P10_PRED: begin
                op_a = OPA_W'(p11_reg);
                op_b = OPB_W'(dt_reg);
            end
            OP_P11_PRED: begin
                op_a = OPA_W'(q_bias_reg);
                op_b = OPB_W'(dt_reg);
            end
            OP_K0: begin
                op_a = OPA_W'(p00_reg);
                op_b = OPB_W'(inv_reg);
            end
            OP_K1: begin
                op_a = OPA_W'(p10_reg);
                op_b = OPB_W'(inv_reg);
            end
            OP_ANG_CORR: begin
                op_a = OPA_W'(k0_reg);
                op_b = OPB_W'(y_reg);
            end
            OP_BIAS_CORR: begin
                op_a = OPA_W'(k1_reg);
                op_b = OPB_W'(y_reg);
            end
            OP_P00_CORR: begin
                op_a = OPA_W'(k0_reg);
                op_b = OPB_W'(p00_reg);
            end
            OP_P01_CORR: begin
                op_a = OPA_W'(k0_reg);
                op_b = OPB_W'(p01_reg);
            end
            OP_P10_CORR: begin
                op_a = OPA_W'(k1_reg);
                op_b = OPB_W'(p00_reg);
            end
            OP_P11_CORR: begin
                op_a = OPA_W'(k1_reg);
                op_b = OPB_W'(p01_reg);
            end
            default: ;
        endcase
    end

    // round half up, then floor; Q16.16 products saturate here
    always_comb begin
        if (is_qq(cmd.op)) begin
            rnd_sum  = prod_reg + (PROD_W'(1) <<< 15);
            rnd_shd  = rnd_sum >>> 16;
            rnd_next = RND_W'(sat32(ACC_W'(signed'(rnd_shd[RND_W-1:0]))));
        end else begin
            rnd_sum  = prod_reg + (PROD_W'(1) <<< 23);
            rnd_shd  = rnd_sum >>> 24;
            rnd_next = signed'(rnd_shd[RND_W-1:0]);
        end
    end

    // accumulate into the step's destination
    always_comb begin
        acc_base = '0;
        acc_sub  = 1'b0;
        case (cmd.op)
            OP_ANG_PRED, OP_ANG_CORR: acc_base = ang_reg;
            OP_BIAS_CORR:             acc_base = bias_reg;
            OP_P00_PRED:              acc_base = p00_reg;
            OP_P11_PRED:              acc_base = p11_reg;
            OP_P00_CORR: begin
                acc_base = p00_reg;
                acc_sub  = 1'b1;
            end
            OP_P01_PRED, OP_P01_CORR: begin
                acc_base = p01_reg;
                acc_sub  = 1'b1;
            end
            OP_P10_PRED, OP_P10_CORR: begin
                acc_base = p10_reg;
                acc_sub  = 1'b1;
            end
            OP_P11_CORR: begin
                acc_base = p11_reg;
                acc_sub  = 1'b1;
            end
            default: ;
        endcase
        acc_sum = acc_sub ? ACC_W'(acc_base) - ACC_W'(rnd_reg)
                          : ACC_W'(acc_base) + ACC_W'(rnd_reg);
        acc_res = sat32(acc_sum);
    end

    assign s_val = S_W'(p00_reg) + S_W'(signed'({1'b0, r_meas_reg}));

    abkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .s_in    (s_val),
        .done    (div_done),
        .inv     (div_inv)
    );

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            axis_reg <= s_axis;
            meas_reg <= s_measured_angle;
            rate_reg <= s_gyro_rate;
            dt_reg   <= s_time_step;
        end
        if (cmd.load && axis_ok) begin
            ang_reg  <= ang_mem[idx];
            bias_reg <= bias_mem[idx];
            p00_reg  <= p00_mem[idx];
            p01_reg  <= p01_mem[idx];
            p10_reg  <= p10_mem[idx];
            p11_reg  <= p11_mem[idx];
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
        if (cmd.rnd) begin
            rnd_reg <= rnd_next;
        end
        if (cmd.acc) begin
            case (cmd.op)
                OP_ANG_PRED, OP_ANG_CORR: ang_reg  <= acc_res;
                OP_BIAS_CORR:             bias_reg <= acc_res;
                OP_P00_PRED, OP_P00_CORR: p00_reg  <= acc_res;
                OP_P01_PRED, OP_P01_CORR: p01_reg  <= acc_res;
                OP_P10_PRED, OP_P10_CORR: p10_reg  <= acc_res;
                OP_P11_PRED, OP_P11_CORR: p11_reg  <= acc_res;
                OP_K0:                    k0_reg   <= acc_res;
                OP_K1:                    k1_reg   <= acc_res;
                default: ;
            endcase
        end
        if (cmd.div_start) begin
            y_reg <= sat32(ACC_W'(meas_reg) - ACC_W'(ang_reg));
        end
        if (div_done) begin
            inv_reg <= div_inv;
        end
        if (cmd.finish) begin
            m_axis_out       <= axis_reg;
            m_angle_estimate <= axis_ok ? ang_reg : '0;
            m_bias_estimate  <= axis_ok ? bias_reg : '0;
        end
    end

    // per-axis state, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_mem[i]  <= '0;
                bias_mem[i] <= '0;
                p00_mem[i]  <= '0;
                p01_mem[i]  <= '0;
                p10_mem[i]  <= '0;
                p11_mem[i]  <= '0;
            end
        end else if (cmd.finish && axis_ok) begin
            ang_mem[idx]  <= ang_reg;
            bias_mem[idx] <= bias_reg;
            p00_mem[idx]  <= p00_reg;
            p01_mem[idx]  <= p01_reg;
            p10_mem[idx]  <= p10_reg;
            p11_mem[idx]  <= p11_reg;
        end
    end

endmodule

// ===== rtl/angle_bias_kalman_filter_top.sv =====
// Top level of the two-state (angle, gyro bias) Kalman filter.
// Depends on abkf_pkg, abkf_ctrl, abkf_dp (and abkf_div below it).
//
// Usage:
//  - Input channel (s_*): one beat per IMU sample: the axis to update, the
//    accelerometer angle and gyro rate (signed Q9.16 and Q12.16) and the time step
//    (unsigned Q0.24). Result channel (m_*): one beat per input beat carrying
//    the axis and the new angle and bias estimates, signed Q16.16, saturated.
//  - Configuration: pulse cfg_wr_en with cfg_addr 0 (angle Q), 1 (bias Q) or
//    2 (measurement R) and the 17-bit value; write only while the filter is idle.
//  - Datapath: each of the 12 multiply steps goes through the single shared
//    multiplier as a multiply, a round and an accumulate, and the reciprocal
//    1/(P00 + R) comes from a restoring divider that retires one quotient bit
//    per cycle over 33 bits.
//  - Flow: one item at a time; s_ready is high only while idle, so a new item
//    is taken only once the last result has gone into the output register.
//  - Stall: the result sits in an output register; the next item can be taken
//    and worked on while it waits, and its result holds until m_ready frees the slot.
//  - Reset (aresetn low, synchronous): state of every axis cleared to zero,
//    noise registers back to their defaults, no result pending.
//  - An axis index of NUM_AXES or more changes no state and returns zero estimates.
module angle_bias_kalman_filter_top
    import abkf_pkg::*;
#(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]         cfg_wdata,
    // input beat
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_axis,
    input  logic signed [MEAS_W-1:0] s_measured_angle,
    input  logic signed [RATE_W-1:0] s_gyro_rate,
    input  logic [DT_W-1:0]          s_time_step,
    // result beat
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_axis_out,
    output logic signed [DATA_W-1:0] m_angle_estimate,
    output logic signed [DATA_W-1:0] m_bias_estimate
);

    abkf_cmd_t    cmd;
    abkf_status_t status;

    // sequence the steps of one update
    abkf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // hold state, do the arithmetic, drive the result payload
    abkf_dp #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_axis           (s_axis),
        .s_measured_angle (s_measured_angle),
        .s_gyro_rate      (s_gyro_rate),
        .s_time_step      (s_time_step),
        .m_axis_out       (m_axis_out),
        .m_angle_estimate (m_angle_estimate),
        .m_bias_estimate  (m_bias_estimate)
    );

endmodule

// ===== tb/sv/tb_angle_bias_kalman_filter_top.sv =====
// Self-checking testbench for angle_bias_kalman_filter_top: directed and random
// IMU beats, a fixed-point filter predictor and a field-by-field result check.
// Depends on abkf_pkg and the filter RTL.
module tb_angle_bias_kalman_filter_top;
    import abkf_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic              axis;
        logic signed [MEAS_W-1:0] meas;
        logic signed [RATE_W-1:0] rate;
        logic [DT_W-1:0]   dt;
    } imu_beat_t;

    typedef struct {
        logic              axis;
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] bias;
    } estimate_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_axis;
    logic signed [MEAS_W-1:0] s_measured_angle;
    logic signed [RATE_W-1:0] s_gyro_rate;
    logic [DT_W-1:0] s_time_step;
    logic m_valid;
    logic m_ready;
    logic m_axis_out;
    logic signed [DATA_W-1:0] m_angle_estimate;
    logic signed [DATA_W-1:0] m_bias_estimate;

    angle_bias_kalman_filter_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_axis           (s_axis),
        .s_measured_angle (s_measured_angle),
        .s_gyro_rate      (s_gyro_rate),
        .s_time_step      (s_time_step),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_axis_out       (m_axis_out),
        .m_angle_estimate (m_angle_estimate),
        .m_bias_estimate  (m_bias_estimate)
    );

    // predictor copy of the filter state and noise registers
    logic [CFG_W-1:0] q_angle;
    logic [CFG_W-1:0] q_bias;
    logic [CFG_W-1:0] r_meas;
    logic signed [31:0] est_angle [NUM_AXES_DEF];
    logic signed [31:0] est_bias  [NUM_AXES_DEF];
    logic signed [31:0] cov00 [NUM_AXES_DEF];
    logic signed [31:0] cov01 [NUM_AXES_DEF];
    logic signed [31:0] cov10 [NUM_AXES_DEF];
    logic signed [31:0] cov11 [NUM_AXES_DEF];

    imu_beat_t pending_beats[$];
    estimate_t expected_estimates[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off_req;
    bit  beat_taken;
    int  quiet_cycles;
    int  error_count;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // add half an LSB, then floor
    function automatic longint round_down(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp32(round_down(a * b, 16));
    endfunction

    // advance one axis filter and return the new estimates
    function automatic estimate_t filter_update(input imu_beat_t b);
        estimate_t e;
        int     a;
        longint ang, bs, p00, p01, p10, p11, dt, d11, y, s, inv, k0, k1;
        a   = int'(b.axis);
        dt  = longint'(b.dt);
        ang = est_angle[a];
        bs  = est_bias[a];
        p00 = cov00[a];
        p01 = cov01[a];
        p10 = cov10[a];
        p11 = cov11[a];
        ang = clamp32(ang + round_down((longint'(b.rate) - bs) * dt, 24));
        p00 = clamp32(p00 + round_down((longint'(q_angle) - p10 - p01) * dt, 24));
        d11 = round_down(p11 * dt, 24);
        p01 = clamp32(p01 - d11);
        p10 = clamp32(p10 - d11);
        p11 = clamp32(p11 + round_down(longint'(q_bias) * dt, 24));
        y   = clamp32(longint'(b.meas) - ang);
        s   = p00 + longint'(r_meas);
        inv = (s == 0) ? 0 : clamp32((64'sd1 <<< 32) / s);
        k0  = qmul(p00, inv);
        k1  = qmul(p10, inv);
        ang = clamp32(ang + qmul(k0, y));
        bs  = clamp32(bs + qmul(k1, y));
        p00 = clamp32(p00 - qmul(k0, p00));
        p01 = clamp32(p01 - qmul(k0, p01));
        p10 = clamp32(p10 - qmul(k1, p00));
        p11 = clamp32(p11 - qmul(k1, p01));
        est_angle[a] = ang[31:0];
        est_bias[a]  = bs[31:0];
        cov00[a] = p00[31:0];
        cov01[a] = p01[31:0];
        cov10[a] = p10[31:0];
        cov11[a] = p11[31:0];
        e.axis  = b.axis;
        e.angle = ang[31:0];
        e.bias  = bs[31:0];
        return e;
    endfunction

    // driver: present the oldest pending beat, idle at random between beats
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || beat_taken)) begin
            beat_taken = 1'b0;
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid          <= 1'b1;
                s_axis           <= pending_beats[0].axis;
                s_measured_angle <= pending_beats[0].meas;
                s_gyro_rate      <= pending_beats[0].rate;
                s_time_step      <= pending_beats[0].dt;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(negedge aclk) begin : recv_proc
        int hold_count;
        if (hold_off_req) begin
            m_ready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count >= HOLD_OFF_CYCLES) begin
                hold_off_req = 1'b0;
                hold_count = 0;
            end
        end else begin
            hold_count = 0;
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge aclk) begin
        estimate_t got;
        estimate_t want;
        if (aresetn) begin
            quiet_cycles = quiet_cycles + 1;
            if (s_valid && s_ready) begin
                quiet_cycles = 0;
                expected_estimates.push_back(filter_update(pending_beats[0]));
                void'(pending_beats.pop_front());
                beat_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                got.axis  = m_axis_out;
                got.angle = m_angle_estimate;
                got.bias  = m_bias_estimate;
                if (expected_estimates.size() == 0) begin
                    $display("%0t: result beat with nothing expected: axis %0d angle %0d bias %0d",
                             $time, got.axis, got.angle, got.bias);
                    error_count++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (got.axis !== want.axis) begin
                        $display("%0t: axis mismatch: expected %0d actual %0d",
                                 $time, want.axis, got.axis);
                        error_count++;
                    end
                    if (got.angle !== want.angle) begin
                        $display("%0t: angle mismatch: expected %0d actual %0d",
                                 $time, want.angle, got.angle);
                        error_count++;
                    end
                    if (got.bias !== want.bias) begin
                        $display("%0t: bias mismatch: expected %0d actual %0d",
                                 $time, want.bias, got.bias);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // write one noise register at a falling edge, only while idle
    task automatic write_noise(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ANGLE_Q: q_angle = val;
            CFG_BIAS_Q:  q_bias  = val;
            CFG_MEAS_R:  r_meas  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_noise(input int qa, input int qb, input int r);
        write_noise(CFG_ANGLE_Q, qa[CFG_W-1:0]);
        write_noise(CFG_BIAS_Q, qb[CFG_W-1:0]);
        write_noise(CFG_MEAS_R, r[CFG_W-1:0]);
    endtask

    task automatic queue_beat(input logic ax, input int meas, input int rate, input int dt);
        imu_beat_t b;
        b.axis = ax;
        b.meas = meas[MEAS_W-1:0];
        b.rate = rate[RATE_W-1:0];
        b.dt   = dt[DT_W-1:0];
        pending_beats.push_back(b);
    endtask

    // mostly realistic IMU samples, some full-range beats
    task automatic queue_random(input int n);
        int meas, rate, dt;
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                meas = int'($urandom_range(23592960)) - 11796480;
                rate = int'($urandom_range(262144000)) - 131072000;
                dt   = int'($urandom_range(24'hFFFFFF));
            end else begin
                meas = int'($urandom_range(5898240)) - 2949120;
                rate = int'($urandom_range(13107200)) - 6553600;
                dt   = int'($urandom_range(335544, 16777));
            end
            queue_beat(1'($urandom_range(1)), meas, rate, dt);
        end
    endtask

    // wait until every beat is sent and every result checked, then let it settle
    task automatic drain;
        while (pending_beats.size() > 0 || expected_estimates.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_axis = 1'b0;
        s_measured_angle = '0;
        s_gyro_rate = '0;
        s_time_step = '0;
        m_ready = 1'b0;
        hold_off_req = 1'b0;
        beat_taken = 1'b0;
        quiet_cycles = 0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        q_angle = ANGLE_Q_RST;
        q_bias = BIAS_Q_RST;
        r_meas = MEAS_R_RST;
        for (int i = 0; i < NUM_AXES_DEF; i++) begin
            est_angle[i] = 0;
            est_bias[i] = 0;
            cov00[i] = 0;
            cov01[i] = 0;
            cov10[i] = 0;
            cov11[i] = 0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero innovation variance: R of zero on fresh state, no elapsed time
        set_noise(0, 0, 0);
        queue_beat(1'b0, 11796480, 131072000, 0);
        queue_beat(1'b1, -11796480, -131072000, 0);
        drain();

        // directed extremes under the reset defaults
        set_noise(int'(ANGLE_Q_RST), int'(BIAS_Q_RST), int'(MEAS_R_RST));
        queue_beat(1'b0, 11796480, 131072000, 24'hFFFFFF);
        queue_beat(1'b0, -11796480, -131072000, 24'hFFFFFF);
        queue_beat(1'b1, -11796480, 131072000, 1);
        queue_beat(1'b1, 11796480, -131072000, 24'hFFFFFF);
        queue_beat(1'b0, 0, 0, 0);
        queue_beat(1'b1, 0, 0, 16777);
        queue_beat(1'b0, 65536, 6553600, 167772);
        queue_beat(1'b1, -1, -1, 8388608);
        drain();

        // no idling on either side
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(200);
        drain();

        // largest noise values, sender idle most of the time
        set_noise(65536, 65536, 65536);
        send_idle_pct = 66;
        recv_stall_pct = 0;
        queue_random(200);
        drain();

        // smallest legal noise, receiver stalling, long hold-off to back up the input
        set_noise(0, 0, 1);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        hold_off_req = 1'b1;
        queue_random(200);
        drain();

        // random noise, both sides idling
        set_noise($urandom_range(65536), $urandom_range(65536), $urandom_range(65536, 1));
        send_idle_pct = 20;
        recv_stall_pct = 20;
        queue_random(200);
        drain();

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
